>>> rtl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// Shared widths, payload types and codes for the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otb_pkg;

   localparam int COUNT_BITS = 21;
   localparam int BIN_COUNT  = 256;
   localparam int BIN_W      = 8;
   localparam int SUM_W      = COUNT_BITS + BIN_W;
   localparam int DIFF_W     = COUNT_BITS + SUM_W;
   localparam int NUM_W      = 2 * DIFF_W;
   localparam int DEN_W      = 2 * COUNT_BITS;
   localparam int CROSS_W    = NUM_W + DEN_W;
   localparam int PROD_W     = NUM_W + DIFF_W;
   localparam int MCNT_W     = $clog2(DIFF_W + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [BIN_W-1:0]      PIX_HIGH  = '1;
   localparam logic [BIN_W-1:0]      PIX_LOW   = '0;
   localparam logic [BIN_W-1:0]      BIN_LAST  = BIN_W'(BIN_COUNT - 1);

   localparam logic ACT_ACCUMULATE = 1'b0;
   localparam logic ACT_APPLY      = 1'b1;

   typedef struct packed {
      logic             action;
      logic [BIN_W-1:0] pixel;
      logic             last_pixel;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0] binary_pixel;
      logic [BIN_W-1:0] threshold_value;
      logic             threshold_fresh;
   } rsp_type;

   // histogram access from the threshold sequencer
   typedef struct packed {
      logic             clr;
      logic [BIN_W-1:0] addr;
   } walk_mem_type;

endpackage

>>> rtl/otb_mul.sv
// ----------------------------------------------------------------------------
// otb_mul
// Shift-add multiplier, one multiplier bit per cycle, for the exact score math.
// ----------------------------------------------------------------------------
module otb_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [otb_pkg::NUM_W-1:0]   op_a,
   input  logic [otb_pkg::DIFF_W-1:0]  op_b,
   output logic                        busy,
   output logic [otb_pkg::PROD_W-1:0]  product
);
   import otb_pkg::*;

   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] a_ff, a_in;
   logic [DIFF_W-1:0] b_ff, b_in;
   logic [MCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         a_in    = PROD_W'(op_a);
         b_in    = op_b;
         cnt_in  = MCNT_W'(DIFF_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in    = a_ff << 1;
         b_in    = b_ff >> 1;
         cnt_in  = cnt_ff - MCNT_W'(1);
         busy_in = (cnt_ff != MCNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

>>> rtl/otb_hist.sv
// ----------------------------------------------------------------------------
// otb_hist
// Histogram memory with a read-modify-write increment path and clear writes.
// ----------------------------------------------------------------------------
module otb_hist (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            acc_en,
   input  logic [otb_pkg::BIN_W-1:0]       acc_bin,
   input  otb_pkg::walk_mem_type           walk,
   output logic [otb_pkg::COUNT_BITS-1:0]  rd_data
);
   import otb_pkg::*;

   logic [COUNT_BITS-1:0] hist_mem_ff [BIN_COUNT];
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic                  st_vld_ff;
   logic [BIN_W-1:0]      st_bin_ff;
   logic                  wr_vld_ff;
   logic [BIN_W-1:0]      wr_bin_ff;
   logic [COUNT_BITS-1:0] wr_data_ff;

   logic [BIN_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [BIN_W-1:0]      wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [COUNT_BITS-1:0] upd;

   assign rd_addr = acc_en ? acc_bin : walk.addr;

   // previous increment to the same bin is not yet visible in the read data
   assign upd = ((wr_vld_ff && (wr_bin_ff == st_bin_ff)) ? wr_data_ff : rd_data_ff)
                + COUNT_BITS'(1);

   assign wr_en   = st_vld_ff || walk.clr;
   assign wr_addr = st_vld_ff ? st_bin_ff : walk.addr;
   assign wr_data = st_vld_ff ? upd : '0;

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem_ff[rd_addr];
      if (wr_en) begin
         hist_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         st_vld_ff <= acc_en;
         wr_vld_ff <= st_vld_ff;
      end
      st_bin_ff  <= acc_bin;
      wr_bin_ff  <= st_bin_ff;
      wr_data_ff <= upd;
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/otb_walk.sv
// ----------------------------------------------------------------------------
// otb_walk
// Sequencer that clears the histogram and walks its bins to pick the threshold.
// ----------------------------------------------------------------------------
module otb_walk (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [otb_pkg::COUNT_BITS-1:0]  total,
   input  logic [otb_pkg::SUM_W-1:0]       wsum,
   input  logic [otb_pkg::COUNT_BITS-1:0]  rd_data,
   input  logic                            out_free,
   output otb_pkg::walk_mem_type           mem_ctl,
   output logic                            idle,
   output logic                            done,
   output logic [otb_pkg::BIN_W-1:0]       thr,
   output logic [otb_pkg::BIN_W-1:0]       pick
);
   import otb_pkg::*;

   typedef enum logic [11:0] {
      S_CLEAR    = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_DRAIN    = 12'b0000_0000_0100,
      S_READ     = 12'b0000_0000_1000,
      S_ADD      = 12'b0000_0001_0000,
      S_CHECK    = 12'b0000_0010_0000,
      S_MUL_GO   = 12'b0000_0100_0000,
      S_MUL_WAIT = 12'b0000_1000_0000,
      S_DIFF     = 12'b0001_0000_0000,
      S_CMP      = 12'b0010_0000_0000,
      S_NEXT     = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   typedef enum logic [2:0] {
      OP_MW,
      OP_UN,
      OP_DD,
      OP_DEN,
      OP_LHS,
      OP_RHS
   } op_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [BIN_W-1:0]      bin_ff, bin_in;
   logic [COUNT_BITS-1:0] w_ff, w_in;
   logic [SUM_W-1:0]      u_ff, u_in;
   logic [DIFF_W-1:0]     mw_ff, mw_in;
   logic [DIFF_W-1:0]     un_ff, un_in;
   logic [DIFF_W-1:0]     d_ff, d_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic [CROSS_W-1:0]    lhs_ff, lhs_in;
   logic [NUM_W-1:0]      best_num_ff, best_num_in;
   logic [DEN_W-1:0]      best_den_ff, best_den_in;
   logic [BIN_W-1:0]      pick_ff, pick_in;
   logic [BIN_W-1:0]      thr_ff, thr_in;

   logic                  mul_start;
   logic                  mul_busy;
   logic [NUM_W-1:0]      mul_a;
   logic [DIFF_W-1:0]     mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic [SUM_W-1:0]      bin_wt;
   logic [COUNT_BITS-1:0] rest;

   otb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .product (mul_p)
   );

   assign bin_wt = SUM_W'(rd_data) * SUM_W'(bin_ff);
   assign rest   = total - w_ff;

   always_comb begin
      case (op_ff)
         OP_MW: begin
            mul_a = NUM_W'(wsum);
            mul_b = DIFF_W'(w_ff);
         end
         OP_UN: begin
            mul_a = NUM_W'(u_ff);
            mul_b = DIFF_W'(total);
         end
         OP_DD: begin
            mul_a = NUM_W'(d_ff);
            mul_b = d_ff;
         end
         OP_DEN: begin
            mul_a = NUM_W'(rest);
            mul_b = DIFF_W'(w_ff);
         end
         OP_LHS: begin
            mul_a = num_ff;
            mul_b = DIFF_W'(best_den_ff);
         end
         OP_RHS: begin
            mul_a = best_num_ff;
            mul_b = DIFF_W'(den_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      bin_in       = bin_ff;
      w_in         = w_ff;
      u_in         = u_ff;
      mw_in        = mw_ff;
      un_in        = un_ff;
      d_in         = d_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      lhs_in       = lhs_ff;
      best_num_in  = best_num_ff;
      best_den_in  = best_den_ff;
      pick_in      = pick_ff;
      thr_in       = thr_ff;
      mul_start    = 1'b0;
      mem_ctl.clr  = 1'b0;
      mem_ctl.addr = bin_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.clr = 1'b1;
            bin_in      = bin_ff + BIN_W'(1);
            if (bin_ff == BIN_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in    = S_DRAIN;
               bin_in      = '0;
               w_in        = '0;
               u_in        = '0;
               best_num_in = '0;
               best_den_in = DEN_W'(1);
               pick_in     = '0;
            end
         end
         // let the last increment land before the first read
         S_DRAIN: begin
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            w_in        = w_ff + rd_data;
            u_in        = u_ff + bin_wt;
            mem_ctl.clr = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            // score undefined with an empty class on either side
            if ((w_ff == '0) || (w_ff >= total)) begin
               state_in = S_NEXT;
            end else begin
               op_in    = OP_MW;
               state_in = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (!mul_busy) begin
               case (op_ff)
                  OP_MW: begin
                     mw_in    = mul_p[DIFF_W-1:0];
                     op_in    = OP_UN;
                     state_in = S_MUL_GO;
                  end
                  OP_UN: begin
                     un_in    = mul_p[DIFF_W-1:0];
                     state_in = S_DIFF;
                  end
                  OP_DD: begin
                     num_in   = mul_p[NUM_W-1:0];
                     op_in    = OP_DEN;
                     state_in = S_MUL_GO;
                  end
                  OP_DEN: begin
                     den_in   = mul_p[DEN_W-1:0];
                     op_in    = OP_LHS;
                     state_in = S_MUL_GO;
                  end
                  OP_LHS: begin
                     lhs_in   = mul_p[CROSS_W-1:0];
                     op_in    = OP_RHS;
                     state_in = S_MUL_GO;
                  end
                  OP_RHS: begin
                     state_in = S_CMP;
                  end
                  default: begin
                     state_in = S_NEXT;
                  end
               endcase
            end
         end
         S_DIFF: begin
            d_in     = (mw_ff >= un_ff) ? (mw_ff - un_ff) : (un_ff - mw_ff);
            op_in    = OP_DD;
            state_in = S_MUL_GO;
         end
         S_CMP: begin
            // strict compare keeps the lowest bin on ties
            if (lhs_ff > mul_p[CROSS_W-1:0]) begin
               best_num_in = num_ff;
               best_den_in = den_ff;
               pick_in     = bin_ff;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (bin_ff == BIN_LAST) begin
               state_in = S_DONE;
            end else begin
               bin_in   = bin_ff + BIN_W'(1);
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (out_free) begin
               thr_in   = pick_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff    <= OP_MW;
         bin_ff   <= '0;
         thr_ff   <= '0;
         pick_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         bin_ff   <= bin_in;
         thr_ff   <= thr_in;
         pick_ff  <= pick_in;
      end
      w_ff        <= w_in;
      u_ff        <= u_in;
      mw_ff       <= mw_in;
      un_ff       <= un_in;
      d_ff        <= d_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      lhs_ff      <= lhs_in;
      best_num_ff <= best_num_in;
      best_den_ff <= best_den_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE) && out_free;
   assign thr  = thr_ff;
   assign pick = pick_ff;

endmodule

>>> rtl/otsu_threshold_binarizer.sv
// Apply: an apply request's result is registered and shows in the cycle after acceptance.
// Accumulate requests are taken one per cycle while the walk is idle; the
// histogram increment is a two-stage read-modify-write on one memory with
// forwarding between requests. Frame end: the bin walk uses one shift-add
// multiplier for six products per bin that leaves both classes non-empty.
// Reset: a clearing pass over every histogram bin, no request taken.
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// Histogram-based Otsu threshold picking and pixel binarization.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  otb_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output otb_pkg::rsp_type  rsp_data
);
   import otb_pkg::*;

   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_fire;
   logic                  acc_fire;
   logic                  app_fire;
   logic                  acc_en;
   logic                  out_free;
   logic                  walk_idle;
   logic                  walk_done;
   logic [BIN_W-1:0]      thr;
   logic [BIN_W-1:0]      pick;
   logic [COUNT_BITS-1:0] rd_data;
   walk_mem_type          mem_ctl;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = walk_idle && (out_free || (req_data.action == ACT_ACCUMULATE));
   assign req_fire  = req_valid && req_ready;
   assign acc_fire  = req_fire && (req_data.action == ACT_ACCUMULATE);
   assign app_fire  = req_fire && (req_data.action == ACT_APPLY);
   // pixels past a full frame counter are dropped
   assign acc_en    = acc_fire && (total_ff != COUNT_MAX);

   otb_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .acc_en  (acc_en),
      .acc_bin (req_data.pixel),
      .walk    (mem_ctl),
      .rd_data (rd_data)
   );

   otb_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .start    (acc_fire && req_data.last_pixel),
      .total    (total_ff),
      .wsum     (sum_ff),
      .rd_data  (rd_data),
      .out_free (out_free),
      .mem_ctl  (mem_ctl),
      .idle     (walk_idle),
      .done     (walk_done),
      .thr      (thr),
      .pick     (pick)
   );

   always_comb begin
      total_in = total_ff;
      sum_in   = sum_ff;
      if (walk_done) begin
         total_in = '0;
         sum_in   = '0;
      end else if (acc_en) begin
         total_in = total_ff + COUNT_BITS'(1);
         sum_in   = sum_ff + SUM_W'(req_data.pixel);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (app_fire) begin
         rsp_valid_in           = 1'b1;
         rsp_in.binary_pixel    = (req_data.pixel > thr) ? PIX_HIGH : PIX_LOW;
         rsp_in.threshold_value = thr;
         rsp_in.threshold_fresh = 1'b0;
      end else if (walk_done) begin
         rsp_valid_in           = 1'b1;
         rsp_in.binary_pixel    = PIX_LOW;
         rsp_in.threshold_value = pick;
         rsp_in.threshold_fresh = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> test/otsu_threshold_binarizer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer_test
// Drives pixel frames and binarize requests into the Otsu binarizer and
// checks each response against an exact integer Otsu predictor kept here.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer_test;
   import otb_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES   = 400;
   localparam int HOLD_CYCLES    = 800;

   typedef logic [191:0] wide_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_req_q[$];
   rsp_type expected_rsp_q[$];

   // predictor state
   logic [COUNT_BITS-1:0] hist[BIN_COUNT];
   logic [COUNT_BITS-1:0] pix_total;
   logic [SUM_W-1:0]      pix_sum;
   logic [BIN_W-1:0]      cur_thresh;

   int  mismatches = 0;
   int  reqs_taken = 0;
   int  burst_left = 0;
   int  gap_left   = 0;
   int  hold_left  = 0;
   bit  hold_done  = 0;
   int  quiet_cycles = 0;
   longint cycle_cnt = 0;

   otsu_threshold_binarizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   function automatic logic [BIN_W-1:0] otsu_pick();
      wide_type n, m, w, u, mw, un, d, num, den, best_num, best_den, lhs, rhs;
      logic [BIN_W-1:0] pick;
      longint run_w, run_u;
      n = wide_type'(pix_total);
      m = wide_type'(pix_sum);
      best_num = '0;
      best_den = wide_type'(1);
      pick = '0;
      run_w = 0;
      run_u = 0;
      for (int i = 0; i < BIN_COUNT; i++) begin
         run_w += hist[i];
         run_u += longint'(hist[i]) * i;
         if (run_w == 0 || run_w >= pix_total) continue;
         w = wide_type'(run_w);
         u = wide_type'(run_u);
         mw = m * w;
         un = u * n;
         d = (mw >= un) ? mw - un : un - mw;
         num = d * d;
         den = w * (n - w);
         lhs = num * best_den;
         rhs = best_num * den;
         if (lhs > rhs) begin
            best_num = num;
            best_den = den;
            pick = BIN_W'(i);
         end
      end
      return pick;
   endfunction

   task automatic predict_request(input req_type r);
      rsp_type e;
      e = '0;
      if (r.action == ACT_APPLY) begin
         e.binary_pixel    = (r.pixel > cur_thresh) ? PIX_HIGH : PIX_LOW;
         e.threshold_value = cur_thresh;
         expected_rsp_q.push_back(e);
      end else begin
         if (pix_total < COUNT_MAX) begin
            hist[r.pixel] += 1;
            pix_total     += 1;
            pix_sum       += r.pixel;
         end
         if (r.last_pixel) begin
            cur_thresh = otsu_pick();
            foreach (hist[i]) hist[i] = '0;
            pix_total = '0;
            pix_sum   = '0;
            e.threshold_value = cur_thresh;
            e.threshold_fresh = 1'b1;
            expected_rsp_q.push_back(e);
         end
      end
   endtask

   // driver: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_request(req_data);
            reqs_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
               req_data  <= pending_req_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: cycles through four stall patterns, plus one long hold
   always @(posedge clock) begin
      cycle_cnt++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && reqs_taken >= 200) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case ((cycle_cnt / 300) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 4) == 0);
            default: rsp_ready <= ((cycle_cnt % 7) < 4);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: got %p", rsp_data);
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_data.binary_pixel !== e.binary_pixel
                || rsp_data.threshold_value !== e.threshold_value
                || rsp_data.threshold_fresh !== e.threshold_fresh) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected bin=%0d thr=%0d fresh=%0b, got bin=%0d thr=%0d fresh=%0b",
                           e.binary_pixel, e.threshold_value, e.threshold_fresh,
                           rsp_data.binary_pixel, rsp_data.threshold_value,
                           rsp_data.threshold_fresh);
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("otsu_threshold_binarizer_test: errors");
            $finish;
         end
      end
   end

   task automatic push_req(input logic act, input logic [BIN_W-1:0] pix, input logic lst);
      req_type r;
      r.action     = act;
      r.pixel      = pix;
      r.last_pixel = lst;
      pending_req_q.push_back(r);
   endtask

   initial begin
      int frame_len, base, spread, total;
      foreach (hist[i]) hist[i] = '0;
      pix_total  = '0;
      pix_sum    = '0;
      cur_thresh = '0;

      // directed: apply at reset threshold, pixel extremes
      push_req(ACT_APPLY, PIX_LOW, 1'b0);
      push_req(ACT_APPLY, PIX_HIGH, 1'b1);
      // single-value frame: no winning bin
      push_req(ACT_ACCUMULATE, 8'd77, 1'b1);
      // two extremes
      push_req(ACT_ACCUMULATE, PIX_LOW, 1'b0);
      push_req(ACT_ACCUMULATE, PIX_HIGH, 1'b0);
      push_req(ACT_ACCUMULATE, PIX_HIGH, 1'b1);
      push_req(ACT_APPLY, PIX_LOW, 1'b0);
      push_req(ACT_APPLY, PIX_HIGH, 1'b0);
      // ties across the empty bins between two values
      push_req(ACT_ACCUMULATE, 8'd10, 1'b0);
      push_req(ACT_ACCUMULATE, 8'd10, 1'b0);
      push_req(ACT_ACCUMULATE, 8'd200, 1'b0);
      push_req(ACT_ACCUMULATE, 8'd200, 1'b1);
      push_req(ACT_APPLY, 8'd10, 1'b1);
      push_req(ACT_APPLY, 8'd11, 1'b0);
      // frame with every bin populated: the longest walk
      for (int i = 0; i < BIN_COUNT; i++)
         push_req(ACT_ACCUMULATE, BIN_W'(i), i == BIN_COUNT - 1);
      push_req(ACT_APPLY, 8'd128, 1'b0);
      push_req(ACT_APPLY, 8'd127, 1'b0);

      // random frames of few distinct values, with binarize requests mixed in
      total = 0;
      while (total < 630) begin
         frame_len = $urandom_range(1, 24);
         base      = $urandom_range(0, 255);
         spread    = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 12);
         for (int k = 0; k < frame_len; k++) begin
            if ($urandom_range(0, 3) == 0) begin
               push_req(ACT_APPLY, BIN_W'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
               total++;
            end
            push_req(ACT_ACCUMULATE,
                     BIN_W'((base + $urandom_range(0, spread)) % BIN_COUNT),
                     k == frame_len - 1);
            total++;
         end
         push_req(ACT_APPLY, BIN_W'($urandom_range(0, 255)), 1'b0);
         total++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      wait (pending_req_q.size() == 0 && !req_valid && expected_rsp_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("otsu_threshold_binarizer_test: clean");
      end else begin
         $display("otsu_threshold_binarizer_test: errors");
      end
      $finish;
   end

endmodule
